@@ hdl/spcr_pkg.sv @@
// Shared types, constants and helper functions for the sphere pair collision resolver.
// No dependencies; every other file of the block but spcr_rsp_if imports this package.
`default_nettype none

package spcr_pkg;

  localparam int unsigned NumBalls = 256;
  localparam int unsigned IdxW     = $clog2(NumBalls);
  localparam int unsigned FracBits = 16;

  localparam int unsigned DivQW    = 18;
  localparam int unsigned DivDenW  = 32;
  localparam int unsigned DivNumW  = DivDenW + DivQW;
  localparam int unsigned SqrtInW  = 64;
  localparam int unsigned SqrtOutW = SqrtInW / 2;

  localparam logic [1:0] CmdWrite   = 2'd0;
  localparam logic [1:0] CmdResolve = 2'd1;
  localparam logic [1:0] CmdRead    = 2'd2;

  localparam logic [1:0] StNoContact  = 2'd0;
  localparam logic [1:0] StResolved   = 2'd1;
  localparam logic [1:0] StDegenerate = 2'd2;

  typedef enum logic [5:0] {
    OP_NONE, OP_ACCEPT, OP_LOAD_A, OP_LOAD_B, OP_DIFF,
    OP_MUL_SQ, OP_ACC_SQ, OP_MUL_RS, OP_SQRT_GO, OP_PEN,
    OP_DIV_N, OP_SET_N, OP_MUL_H, OP_APPLY_H, OP_MUL_C, OP_ACC_C,
    OP_MUL_S, OP_SET_S, OP_DIV_W1, OP_SET_W1, OP_DIV_W2, OP_SET_W2,
    OP_MUL_G1, OP_SET_G1, OP_MUL_G2, OP_SET_G2,
    OP_MUL_V1, OP_APPLY_V1, OP_MUL_V2, OP_APPLY_V2,
    OP_WR_A, OP_WR_B, OP_OUT_READ, OP_OUT_PAIR
  } op_e;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [30:0]      radius;
    logic [30:0]      mass;
    logic [16:0]      bounce;
  } ball_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [IdxW-1:0]  first_index;
    logic [IdxW-1:0]  second_index;
    ball_t            ball;
  } req_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [1:0]       pair_status;
  } rsp_t;

  typedef struct packed {
    op_e        op;
    logic [1:0] axis;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic early_out;
    logic no_contact;
    logic degenerate;
    logic sqrt_busy;
    logic div_busy;
    logic out_busy;
  } dp_stat_t;

  function automatic logic [32:0] mag33(logic [32:0] v);
    return v[32] ? 33'(-v) : v;
  endfunction

  function automatic logic [36:0] mag37(logic [36:0] v);
    return v[36] ? 37'(-v) : v;
  endfunction

  function automatic logic [17:0] mag18(logic [17:0] v);
    return v[17] ? 18'(-v) : v;
  endfunction

  function automatic logic [31:0] sat32(logic [55:0] v);
    if (!v[55] && (|v[54:31])) return 32'h7FFF_FFFF;
    if (v[55] && !(&v[54:31])) return 32'h8000_0000;
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/spcr_req_if.sv @@
// Request channel of the collision resolver: valid, ready and the request fields.
// Depends on spcr_pkg for the index width.
`default_nettype none

interface spcr_req_if import spcr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [IdxW-1:0]    first_index;
  logic [IdxW-1:0]    second_index;
  logic signed [31:0] in_pos_x;
  logic signed [31:0] in_pos_y;
  logic signed [31:0] in_pos_z;
  logic signed [31:0] in_vel_x;
  logic signed [31:0] in_vel_y;
  logic signed [31:0] in_vel_z;
  logic [30:0]        in_radius;
  logic [30:0]        in_mass;
  logic [16:0]        in_bounce;

  modport source (output valid, cmd, first_index, second_index, in_pos_x, in_pos_y,
                  in_pos_z, in_vel_x, in_vel_y, in_vel_z, in_radius, in_mass,
                  in_bounce, input ready);
  modport sink (input valid, cmd, first_index, second_index, in_pos_x, in_pos_y,
                in_pos_z, in_vel_x, in_vel_y, in_vel_z, in_radius, in_mass,
                in_bounce, output ready);
endinterface

`default_nettype wire

@@ hdl/spcr_rsp_if.sv @@
// Result channel of the collision resolver: valid, ready and the result fields.
// No dependencies beyond the language.
`default_nettype none

interface spcr_rsp_if ();
  logic               valid;
  logic               ready;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_pos_z;
  logic signed [31:0] out_vel_x;
  logic signed [31:0] out_vel_y;
  logic signed [31:0] out_vel_z;
  logic [1:0]         pair_status;

  modport source (output valid, out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y,
                  out_vel_z, pair_status, input ready);
  modport sink (input valid, out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y,
                out_vel_z, pair_status, output ready);
endinterface

`default_nettype wire

@@ hdl/spcr_divider.sv @@
// Restoring divider producing one quotient bit per cycle.
// Depends on spcr_pkg for the operand widths.
`default_nettype none

module spcr_divider import spcr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [DivDenW-1:0] den_i,
  output logic               busy_o,
  output logic [DivQW-1:0]   quot_o
);

  localparam int unsigned CntW = $clog2(DivQW + 1);

  logic               busy_q;
  logic [CntW-1:0]    cnt_q;
  logic [DivDenW-1:0] rem_q;
  logic [DivDenW-1:0] den_q;
  logic [DivQW-1:0]   low_q;
  logic [DivQW-1:0]   quot_q;
  logic [DivDenW:0]   trial;
  logic [DivDenW:0]   diff;
  logic               ge;

  assign trial = {rem_q, low_q[DivQW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(DivQW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[DivNumW-1:DivQW];
      low_q <= num_i[DivQW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
      low_q  <= {low_q[DivQW-2:0], 1'b0};
      quot_q <= {quot_q[DivQW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

@@ hdl/spcr_sqrt.sv @@
// Integer square root, one result bit per cycle, rounding down.
// Depends on spcr_pkg for the operand widths.
`default_nettype none

module spcr_sqrt import spcr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [SqrtInW-1:0]  rad_i,
  output logic                busy_o,
  output logic [SqrtOutW-1:0] root_o
);

  localparam int unsigned CntW = $clog2(SqrtOutW + 1);
  localparam int unsigned RemW = SqrtOutW + 2;

  logic                busy_q;
  logic [CntW-1:0]     cnt_q;
  logic [RemW-1:0]     rem_q;
  logic [SqrtOutW-1:0] root_q;
  logic [SqrtInW-1:0]  rad_q;
  logic [RemW+1:0]     t;
  logic [RemW+1:0]     trial;
  logic [RemW+1:0]     diff;
  logic                ge;

  assign t     = {rem_q, rad_q[SqrtInW-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = t >= trial;
  assign diff  = t - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(SqrtOutW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      root_q <= '0;
      rad_q  <= rad_i;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[RemW-1:0] : t[RemW-1:0];
      root_q <= {root_q[SqrtOutW-2:0], ge};
      rad_q  <= {rad_q[SqrtInW-3:0], 2'b00};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

@@ hdl/spcr_datapath.sv @@
// Datapath: ball table, working registers, shared multiplier, square root and divider.
// Depends on spcr_pkg, spcr_sqrt and spcr_divider; steered by spcr_ctrl.
`default_nettype none

module spcr_datapath import spcr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  req_t     req_i,
  input  dp_cmd_t  cmd_i,
  output dp_stat_t stat_o,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  output rsp_t     rsp_o
);

  ball_t ball_mem_q [NumBalls];
  ball_t rd_q;
  ball_t a_q;
  ball_t b_q;
  ball_t wdata;
  logic            mem_we;
  logic [IdxW-1:0] waddr;
  logic [IdxW-1:0] rd_addr;
  logic [IdxW-1:0] idx_a_q;
  logic [IdxW-1:0] idx_b_q;

  logic [2:0][32:0] d_q;
  logic [2:0][32:0] absd;
  logic [32:0]      radsum_q;
  logic [31:0]      msum_q;
  logic [65:0]      sum_q;
  logic [32:0]      pen_q;
  logic [2:0][17:0] n_q;
  logic [36:0]      c_q;
  logic [36:0]      s_q;
  logic [36:0]      g1_q;
  logic [36:0]      g2_q;
  logic [16:0]      w1_q;
  logic [16:0]      w2_q;

  logic [36:0] ma;
  logic [31:0] mb;
  logic        mneg;
  logic [68:0] p_q;
  logic        pneg_q;
  logic [68:0] t16;
  logic [68:0] t17;
  logic signed [53:0] rs16;
  logic signed [53:0] rs17;
  logic [17:0] n_sel;
  logic [17:0] n_mag;
  logic [32:0] vr;
  logic [18:0] bsum;

  logic                sqrt_start;
  logic                sqrt_busy;
  logic [SqrtOutW-1:0] root;
  logic                div_start;
  logic [DivNumW-1:0]  div_num;
  logic [DivDenW-1:0]  div_den;
  logic                div_busy;
  logic [DivQW-1:0]    quot;

  logic rsp_valid_q;
  rsp_t rsp_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      absd[k] = mag33(d_q[k]);
    end
  end

  assign n_sel = n_q[cmd_i.axis];
  assign n_mag = mag18(n_sel);
  assign vr    = 33'($signed(a_q.vel[cmd_i.axis])) - 33'($signed(b_q.vel[cmd_i.axis]));
  assign bsum  = 19'(32'd1 << (FracBits + 1)) + 19'(a_q.bounce) + 19'(b_q.bounce);

  // Ball table: one write port and one registered read port.
  always_comb begin
    mem_we  = 1'b0;
    waddr   = idx_a_q;
    wdata   = a_q;
    rd_addr = idx_a_q;
    unique case (cmd_i.op)
      OP_ACCEPT: begin
        mem_we  = req_i.cmd == CmdWrite;
        waddr   = req_i.first_index;
        wdata   = req_i.ball;
        rd_addr = req_i.first_index;
      end
      OP_LOAD_A: rd_addr = idx_b_q;
      OP_WR_A:   mem_we = 1'b1;
      OP_WR_B: begin
        mem_we = 1'b1;
        waddr  = idx_b_q;
        wdata  = b_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ball_mem_q[waddr] <= wdata;
    end
    rd_q <= ball_mem_q[rd_addr];
  end

  // Shared multiplier on magnitudes; the sign is carried alongside.
  always_comb begin
    ma   = '0;
    mb   = '0;
    mneg = 1'b0;
    unique case (cmd_i.op)
      OP_MUL_SQ: begin
        ma = 37'(absd[cmd_i.axis]);
        mb = absd[cmd_i.axis][31:0];
      end
      OP_MUL_RS: begin
        ma = 37'(radsum_q);
        mb = radsum_q[31:0];
      end
      OP_MUL_H: begin
        ma   = 37'(pen_q);
        mb   = 32'(n_mag);
        mneg = n_sel[17];
      end
      OP_MUL_C: begin
        ma   = 37'(mag33(vr));
        mb   = 32'(n_mag);
        mneg = vr[32] ^ n_sel[17];
      end
      OP_MUL_S: begin
        ma   = mag37(c_q);
        mb   = 32'(bsum);
        mneg = c_q[36];
      end
      OP_MUL_G1: begin
        ma   = mag37(s_q);
        mb   = 32'(w1_q);
        mneg = s_q[36];
      end
      OP_MUL_G2: begin
        ma   = mag37(s_q);
        mb   = 32'(w2_q);
        mneg = s_q[36];
      end
      OP_MUL_V1: begin
        ma   = mag37(g1_q);
        mb   = 32'(n_mag);
        mneg = g1_q[36] ^ n_sel[17];
      end
      OP_MUL_V2: begin
        ma   = mag37(g2_q);
        mb   = 32'(n_mag);
        mneg = g2_q[36] ^ n_sel[17];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q    <= 69'(ma) * 69'(mb);
    pneg_q <= mneg;
  end

  // Rounding half away from zero after the shift.
  assign t16  = p_q + 69'(32'd1 << (FracBits - 1));
  assign t17  = p_q + 69'(32'd1 << FracBits);
  assign rs16 = pneg_q ? -$signed({1'b0, t16[68:16]}) : $signed({1'b0, t16[68:16]});
  assign rs17 = pneg_q ? -$signed({2'b00, t17[68:17]}) : $signed({2'b00, t17[68:17]});

  assign sqrt_start = cmd_i.op == OP_SQRT_GO;
  assign div_start  = (cmd_i.op == OP_DIV_N) || (cmd_i.op == OP_DIV_W1) ||
                      (cmd_i.op == OP_DIV_W2);

  always_comb begin
    div_num = (DivNumW'(absd[cmd_i.axis]) << FracBits) + DivNumW'(root >> 1);
    div_den = root;
    if (cmd_i.op == OP_DIV_W1) begin
      div_num = (DivNumW'(b_q.mass) << FracBits) + DivNumW'(msum_q >> 1);
      div_den = msum_q;
    end else if (cmd_i.op == OP_DIV_W2) begin
      div_num = (DivNumW'(a_q.mass) << FracBits) + DivNumW'(msum_q >> 1);
      div_den = msum_q;
    end
  end

  spcr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sum_q[SqrtInW-1:0]),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  spcr_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_ACCEPT: begin
        idx_a_q <= req_i.first_index;
        idx_b_q <= req_i.second_index;
      end
      OP_LOAD_A: a_q <= rd_q;
      OP_LOAD_B: b_q <= rd_q;
      OP_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          d_q[k] <= 33'($signed(a_q.pos[k])) - 33'($signed(b_q.pos[k]));
        end
        radsum_q <= 33'(a_q.radius) + 33'(b_q.radius);
        msum_q   <= 32'(a_q.mass) + 32'(b_q.mass);
        sum_q    <= '0;
        c_q      <= '0;
      end
      OP_ACC_SQ: sum_q <= sum_q + p_q[65:0];
      OP_PEN:    pen_q <= radsum_q - 33'(root);
      OP_SET_N:  n_q[cmd_i.axis] <= d_q[cmd_i.axis][32] ? quot : 18'(-quot);
      OP_APPLY_H: begin
        b_q.pos[cmd_i.axis] <= sat32(56'($signed(b_q.pos[cmd_i.axis])) + 56'(rs17));
        a_q.pos[cmd_i.axis] <= sat32(56'($signed(a_q.pos[cmd_i.axis])) - 56'(rs17));
      end
      OP_ACC_C:  c_q  <= c_q + 37'(rs16);
      OP_SET_S:  s_q  <= 37'(rs17);
      OP_SET_W1: w1_q <= quot[16:0];
      OP_SET_W2: w2_q <= quot[16:0];
      OP_SET_G1: g1_q <= 37'(rs16);
      OP_SET_G2: g2_q <= 37'(rs16);
      OP_APPLY_V1:
        a_q.vel[cmd_i.axis] <= sat32(56'($signed(a_q.vel[cmd_i.axis])) - 56'(rs16));
      OP_APPLY_V2:
        b_q.vel[cmd_i.axis] <= sat32(56'($signed(b_q.vel[cmd_i.axis])) + 56'(rs16));
      OP_OUT_READ: begin
        rsp_q.pos         <= a_q.pos;
        rsp_q.vel         <= a_q.vel;
        rsp_q.pair_status <= StNoContact;
      end
      OP_OUT_PAIR: begin
        rsp_q.pos         <= '0;
        rsp_q.vel         <= '0;
        rsp_q.pair_status <= cmd_i.status;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_OUT_READ || cmd_i.op == OP_OUT_PAIR) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  assign stat_o.early_out  = (absd[0] > radsum_q) || (absd[1] > radsum_q) ||
                             (absd[2] > radsum_q);
  assign stat_o.no_contact = (|sum_q[65:64]) || (sum_q[63:0] >= p_q[63:0]);
  assign stat_o.degenerate = (sum_q == '0) || (msum_q == '0);
  assign stat_o.sqrt_busy  = sqrt_busy;
  assign stat_o.div_busy   = div_busy;
  assign stat_o.out_busy   = rsp_valid_q && !rsp_ready_i;

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

@@ hdl/spcr_ctrl.sv @@
// Controller state machine that sequences each request through the datapath.
// Depends on spcr_pkg for the command and status structs.
`default_nettype none

module spcr_ctrl import spcr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  input  logic [1:0] req_cmd_i,
  output logic       req_ready_o,
  input  dp_stat_t   stat_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [5:0] S_IDLE  = 6'd0;
  localparam logic [5:0] S_LDA   = 6'd1;
  localparam logic [5:0] S_LDB   = 6'd2;
  localparam logic [5:0] S_DIFF  = 6'd3;
  localparam logic [5:0] S_EARLY = 6'd4;
  localparam logic [5:0] S_SQM   = 6'd5;
  localparam logic [5:0] S_SQA   = 6'd6;
  localparam logic [5:0] S_RSM   = 6'd7;
  localparam logic [5:0] S_CHK   = 6'd8;
  localparam logic [5:0] S_SQW   = 6'd9;
  localparam logic [5:0] S_NDV   = 6'd10;
  localparam logic [5:0] S_NDW   = 6'd11;
  localparam logic [5:0] S_HM    = 6'd12;
  localparam logic [5:0] S_HA    = 6'd13;
  localparam logic [5:0] S_CM    = 6'd14;
  localparam logic [5:0] S_CA    = 6'd15;
  localparam logic [5:0] S_SM    = 6'd16;
  localparam logic [5:0] S_SS    = 6'd17;
  localparam logic [5:0] S_W1D   = 6'd18;
  localparam logic [5:0] S_W1W   = 6'd19;
  localparam logic [5:0] S_W2D   = 6'd20;
  localparam logic [5:0] S_W2W   = 6'd21;
  localparam logic [5:0] S_G1M   = 6'd22;
  localparam logic [5:0] S_G1S   = 6'd23;
  localparam logic [5:0] S_G2M   = 6'd24;
  localparam logic [5:0] S_G2S   = 6'd25;
  localparam logic [5:0] S_V1M   = 6'd26;
  localparam logic [5:0] S_V1A   = 6'd27;
  localparam logic [5:0] S_V2M   = 6'd28;
  localparam logic [5:0] S_V2A   = 6'd29;
  localparam logic [5:0] S_WRA   = 6'd30;
  localparam logic [5:0] S_WRB   = 6'd31;
  localparam logic [5:0] S_DONE  = 6'd32;

  logic [5:0] state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic [1:0] status_q, status_d;
  logic       is_read_q, is_read_d;
  logic       last_axis;

  assign last_axis   = axis_q == 2'd2;
  assign req_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    status_d    = status_q;
    is_read_d   = is_read_q;
    cmd_o.op    = OP_NONE;
    cmd_o.axis  = axis_q;
    cmd_o.status = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          if (req_cmd_i == CmdRead) begin
            is_read_d = 1'b1;
            state_d   = S_LDA;
          end else if (req_cmd_i == CmdResolve) begin
            is_read_d = 1'b0;
            state_d   = S_LDA;
          end
        end
      end
      S_LDA: begin
        cmd_o.op = OP_LOAD_A;
        if (is_read_q) begin
          status_d = StNoContact;
          state_d  = S_DONE;
        end else begin
          state_d = S_LDB;
        end
      end
      S_LDB: begin
        cmd_o.op = OP_LOAD_B;
        state_d  = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.op = OP_DIFF;
        state_d  = S_EARLY;
      end
      S_EARLY: begin
        axis_d = 2'd0;
        if (stat_i.early_out) begin
          status_d = StNoContact;
          state_d  = S_DONE;
        end else begin
          state_d = S_SQM;
        end
      end
      S_SQM: begin
        cmd_o.op = OP_MUL_SQ;
        state_d  = S_SQA;
      end
      S_SQA: begin
        cmd_o.op = OP_ACC_SQ;
        axis_d   = last_axis ? 2'd0 : axis_q + 2'd1;
        state_d  = last_axis ? S_RSM : S_SQM;
      end
      S_RSM: begin
        cmd_o.op = OP_MUL_RS;
        state_d  = S_CHK;
      end
      S_CHK: begin
        priority if (stat_i.no_contact) begin
          status_d = StNoContact;
          state_d  = S_DONE;
        end else if (stat_i.degenerate) begin
          status_d = StDegenerate;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = OP_SQRT_GO;
          state_d  = S_SQW;
        end
      end
      S_SQW: begin
        if (!stat_i.sqrt_busy) begin
          cmd_o.op = OP_PEN;
          state_d  = S_NDV;
        end
      end
      S_NDV: begin
        cmd_o.op = OP_DIV_N;
        state_d  = S_NDW;
      end
      S_NDW: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = OP_SET_N;
          axis_d   = last_axis ? 2'd0 : axis_q + 2'd1;
          state_d  = last_axis ? S_HM : S_NDV;
        end
      end
      S_HM: begin
        cmd_o.op = OP_MUL_H;
        state_d  = S_HA;
      end
      S_HA: begin
        cmd_o.op = OP_APPLY_H;
        axis_d   = last_axis ? 2'd0 : axis_q + 2'd1;
        state_d  = last_axis ? S_CM : S_HM;
      end
      S_CM: begin
        cmd_o.op = OP_MUL_C;
        state_d  = S_CA;
      end
      S_CA: begin
        cmd_o.op = OP_ACC_C;
        axis_d   = last_axis ? 2'd0 : axis_q + 2'd1;
        state_d  = last_axis ? S_SM : S_CM;
      end
      S_SM: begin
        cmd_o.op = OP_MUL_S;
        state_d  = S_SS;
      end
      S_SS: begin
        cmd_o.op = OP_SET_S;
        state_d  = S_W1D;
      end
      S_W1D: begin
        cmd_o.op = OP_DIV_W1;
        state_d  = S_W1W;
      end
      S_W1W: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = OP_SET_W1;
          state_d  = S_W2D;
        end
      end
      S_W2D: begin
        cmd_o.op = OP_DIV_W2;
        state_d  = S_W2W;
      end
      S_W2W: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = OP_SET_W2;
          state_d  = S_G1M;
        end
      end
      S_G1M: begin
        cmd_o.op = OP_MUL_G1;
        state_d  = S_G1S;
      end
      S_G1S: begin
        cmd_o.op = OP_SET_G1;
        state_d  = S_G2M;
      end
      S_G2M: begin
        cmd_o.op = OP_MUL_G2;
        state_d  = S_G2S;
      end
      S_G2S: begin
        cmd_o.op = OP_SET_G2;
        axis_d   = 2'd0;
        state_d  = S_V1M;
      end
      S_V1M: begin
        cmd_o.op = OP_MUL_V1;
        state_d  = S_V1A;
      end
      S_V1A: begin
        cmd_o.op = OP_APPLY_V1;
        axis_d   = last_axis ? 2'd0 : axis_q + 2'd1;
        state_d  = last_axis ? S_V2M : S_V1M;
      end
      S_V2M: begin
        cmd_o.op = OP_MUL_V2;
        state_d  = S_V2A;
      end
      S_V2A: begin
        cmd_o.op = OP_APPLY_V2;
        axis_d   = last_axis ? 2'd0 : axis_q + 2'd1;
        state_d  = last_axis ? S_WRA : S_V2M;
      end
      S_WRA: begin
        cmd_o.op = OP_WR_A;
        state_d  = S_WRB;
      end
      S_WRB: begin
        cmd_o.op = OP_WR_B;
        status_d = StResolved;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = is_read_q ? OP_OUT_READ : OP_OUT_PAIR;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      axis_q    <= 2'd0;
      status_q  <= StNoContact;
      is_read_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      axis_q    <= axis_d;
      status_q  <= status_d;
      is_read_q <= is_read_d;
    end
  end

`ifndef ASSERT_OFF
  a_accept_handshake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_ACCEPT |-> req_valid_i && req_ready_o)
    else $error("request latched without a handshake");

  a_writeback_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_WR_A |=> cmd_o.op == OP_WR_B)
    else $error("second ball not written back after the first");

  a_sqrt_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_SQRT_GO |-> !stat_i.sqrt_busy)
    else $error("square root restarted while busy");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_DIV_N || cmd_o.op == OP_DIV_W1 || cmd_o.op == OP_DIV_W2)
      |-> !stat_i.div_busy)
    else $error("divider restarted while busy");

  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    axis_q != 2'd3)
    else $error("axis counter out of range");
`endif

endmodule

`default_nettype wire

@@ hdl/sphere_pair_collision_resolver.sv @@
// Write requests give no result; a read gives its result once the entry has been loaded.
// A resolve that fails the per-axis test or the distance test ends early, and a full resolve
// is dominated by the 32-step square root and five 18-step divisions. One request is in work
// at a time. Reset is asynchronous and active low; the ball table is not cleared and reads as
// undefined until each entry has been written. Depends on spcr_pkg, the interfaces and all
// submodules.
`default_nettype none

module sphere_pair_collision_resolver import spcr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  spcr_req_if.sink          req_i,
  spcr_rsp_if.source        rsp_o
);

  req_t     req;
  rsp_t     rsp;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     rsp_valid;
  logic     req_ready;

  assign req.cmd          = req_i.cmd;
  assign req.first_index  = req_i.first_index;
  assign req.second_index = req_i.second_index;
  assign req.ball.pos     = {req_i.in_pos_z, req_i.in_pos_y, req_i.in_pos_x};
  assign req.ball.vel     = {req_i.in_vel_z, req_i.in_vel_y, req_i.in_vel_x};
  assign req.ball.radius  = req_i.in_radius;
  assign req.ball.mass    = req_i.in_mass;
  assign req.ball.bounce  = req_i.in_bounce;

  spcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_cmd_i   (req_i.cmd),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  spcr_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_o       (rsp)
  );

  assign req_i.ready       = req_ready;
  assign rsp_o.valid       = rsp_valid;
  assign rsp_o.out_pos_x   = rsp.pos[0];
  assign rsp_o.out_pos_y   = rsp.pos[1];
  assign rsp_o.out_pos_z   = rsp.pos[2];
  assign rsp_o.out_vel_x   = rsp.vel[0];
  assign rsp_o.out_vel_y   = rsp.vel[1];
  assign rsp_o.out_vel_z   = rsp.vel[2];
  assign rsp_o.pair_status = rsp.pair_status;

endmodule

`default_nettype wire
